FILE: src/hte_pkg.sv
// Shared types, constants and helpers for the homogeneous transform engine.
// No dependencies; every other file in src imports this package.
package hte_pkg;

    // Number formats and sizes
    localparam int FRAC_BITS = 16;
    localparam int DIM       = 4;
    localparam int NCH       = 4;
    localparam int WW        = 32;
    localparam int PW        = 2 * WW;
    localparam int SW        = PW + 2;
    localparam int CIW       = $clog2(NCH);
    localparam int CW        = $clog2(DIM + 1);
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = $clog2(QDEPTH + 1);

    typedef logic signed [WW-1:0] t_word;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [PW:0]   t_pair;
    typedef logic signed [SW-1:0] t_sum;

    // Command codes on the input channel
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STAGE = 2'd1;
    localparam logic [1:0] CMD_XFORM = 2'd2;
    localparam logic [1:0] CMD_IDENT = 2'd3;

    // Operation codes after classification
    localparam logic [2:0] OP_NOP     = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_STAGE   = 3'd2;
    localparam logic [2:0] OP_COMPOSE = 3'd3;
    localparam logic [2:0] OP_XFORM   = 3'd4;
    localparam logic [2:0] OP_IDENT   = 3'd5;

    localparam t_word ONE_FX = t_word'(longint'(1) << FRAC_BITS);

    // Classified request held in the queue
    typedef struct packed {
        logic [2:0]         op;
        logic [1:0]         row;
        t_word [NCH-1:0]    val;
    } t_req;

    // One saturated component and its clip flag
    typedef struct packed {
        logic  sat;
        t_word val;
    } t_res;

    // Floor-shift an exact product sum and clip it to the word range
    function automatic t_res shift_sat(input t_sum s);
        t_sum sh;
        t_res r;
        sh = s >>> FRAC_BITS;
        r.sat = !((&sh[SW-1:WW-1]) || !(|sh[SW-1:WW-1]));
        if (r.sat) begin
            r.val = sh[SW-1] ? t_word'({1'b1, {(WW-1){1'b0}}})
                             : t_word'({1'b0, {(WW-1){1'b1}}});
        end else begin
            r.val = t_word'(sh[WW-1:0]);
        end
        return r;
    endfunction

endpackage

FILE: src/hte_front.sv
// Front end: takes requests from the input channel and classifies them.
// Depends on hte_pkg; pushes classified requests into hte_queue.
module hte_front (
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_command,
    input  logic [1:0]       i_row_index,
    input  hte_pkg::t_word   i_val_0,
    input  hte_pkg::t_word   i_val_1,
    input  hte_pkg::t_word   i_val_2,
    input  hte_pkg::t_word   i_val_3,
    input  logic             i_q_full,
    output logic             o_q_push,
    output hte_pkg::t_req    o_q_req
);
    import hte_pkg::*;

    logic row_ok;

    // Take a request whenever the queue has room
    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;

    assign row_ok = int'(i_row_index) < DIM;

    // Classify: rows beyond the matrix size do nothing, last staged row composes
    always_comb begin
        o_q_req.row    = i_row_index;
        o_q_req.val[0] = i_val_0;
        o_q_req.val[1] = i_val_1;
        o_q_req.val[2] = i_val_2;
        o_q_req.val[3] = i_val_3;
        case (i_command)
            CMD_LOAD:  o_q_req.op = row_ok ? OP_LOAD : OP_NOP;
            CMD_STAGE: begin
                if (!row_ok) begin
                    o_q_req.op = OP_NOP;
                end else if (int'(i_row_index) == DIM - 1) begin
                    o_q_req.op = OP_COMPOSE;
                end else begin
                    o_q_req.op = OP_STAGE;
                end
            end
            CMD_XFORM: o_q_req.op = OP_XFORM;
            CMD_IDENT: o_q_req.op = OP_IDENT;
            default:   o_q_req.op = OP_NOP;
        endcase
    end

endmodule

FILE: src/hte_queue.sv
// Short request queue between the front end and the back end.
// Depends on hte_pkg for the request type and depth.
module hte_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hte_pkg::t_req   i_req,
    input  logic            i_pop,
    output hte_pkg::t_req   o_req,
    output logic            o_valid,
    output logic            o_full
);
    import hte_pkg::*;

    t_req            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wptr;
    logic [QAW-1:0]  r_rptr;
    logic [QCW-1:0]  r_count;
    logic [QCW-1:0]  n_count;

    assign o_valid = r_count != '0;
    assign o_full  = int'(r_count) == QDEPTH;
    assign o_req   = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCW'(1);
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
        end
    end

    // Hold request payloads
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

endmodule

FILE: src/hte_back.sv
// Back end: holds the current and staged matrices and runs the multiply
// pipeline for vector transforms and column-by-column composition. Uses hte_pkg.
module hte_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  hte_pkg::t_req                 i_q_req,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output hte_pkg::t_word [hte_pkg::NCH-1:0] o_out,
    output logic                          o_saturated
);
    import hte_pkg::*;

    // Matrices
    t_word r_cur  [NCH][NCH];
    t_word r_stg  [NCH][NCH];
    t_word r_cbuf [NCH][NCH];

    // Compose sequencing
    logic          r_busy;
    logic [CW-1:0] r_issue;

    // Pipeline stages
    logic           r_s1_v;
    logic           r_s1_c;
    logic [CIW-1:0] r_s1_col;
    t_prod          r_s1_p [NCH][NCH];
    logic           r_s2_v;
    logic           r_s2_c;
    logic [CIW-1:0] r_s2_col;
    t_pair          r_s2_a [NCH];
    t_pair          r_s2_b [NCH];

    // Output register
    logic            r_out_valid;
    t_word [NCH-1:0] r_out;
    logic            r_sat;

    logic           adv;
    logic           pop;
    logic           issue_x;
    logic           issue_c;
    logic [CIW-1:0] col;
    t_word          opnd [NCH];
    t_prod          n_prod [NCH][NCH];
    t_res           res [NCH];
    logic           any_sat;
    logic           s2_last;

    // Whole pipeline moves unless a finished result is waiting
    assign adv     = !r_out_valid || i_ready;
    assign pop     = i_q_valid && !r_busy && adv;
    assign issue_x = pop && (i_q_req.op == OP_XFORM);
    assign issue_c = r_busy && (int'(r_issue) < DIM) && adv;
    assign col     = r_issue[CIW-1:0];
    assign o_q_pop = pop;
    assign s2_last = int'(r_s2_col) == DIM - 1;

    // Select multiplier operands: input vector or a staged column
    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            opnd[k] = issue_c ? r_stg[k][col] : i_q_req.val[k];
        end
        for (int i = 0; i < NCH; i++) begin
            for (int k = 0; k < NCH; k++) begin
                if (i < DIM && k < DIM) begin
                    n_prod[i][k] = $signed(r_cur[i][k]) * $signed(opnd[k]);
                end else begin
                    n_prod[i][k] = '0;
                end
            end
        end
    end

    // Final sum, floor shift and clip per row
    always_comb begin
        any_sat = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            res[i] = shift_sat(t_sum'(r_s2_a[i]) + t_sum'(r_s2_b[i]));
            if (i >= DIM) begin
                res[i] = '0;
            end
            any_sat = any_sat | res[i].sat;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_issue     <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_v      <= issue_x || issue_c;
                r_s2_v      <= r_s1_v;
                r_out_valid <= r_s2_v && !r_s2_c;
            end
            if (pop && i_q_req.op == OP_COMPOSE) begin
                r_busy  <= 1'b1;
                r_issue <= '0;
            end else if (issue_c) begin
                r_issue <= r_issue + CW'(1);
            end
            if (adv && r_s2_v && r_s2_c && s2_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Current and staged matrices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                for (int j = 0; j < NCH; j++) begin
                    r_cur[i][j] <= (i == j && i < DIM) ? ONE_FX : '0;
                    r_stg[i][j] <= '0;
                end
            end
        end else begin
            if (pop) begin
                case (i_q_req.op)
                    OP_LOAD: begin
                        for (int j = 0; j < NCH; j++) begin
                            if (j < DIM) begin
                                r_cur[i_q_req.row][j] <= i_q_req.val[j];
                            end
                        end
                    end
                    OP_STAGE, OP_COMPOSE: begin
                        for (int j = 0; j < NCH; j++) begin
                            if (j < DIM) begin
                                r_stg[i_q_req.row][j] <= i_q_req.val[j];
                            end
                        end
                    end
                    OP_IDENT: begin
                        for (int i = 0; i < NCH; i++) begin
                            for (int j = 0; j < NCH; j++) begin
                                r_cur[i][j] <= (i == j && i < DIM) ? ONE_FX : '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            // Replace the current matrix once the last column is done
            if (adv && r_s2_v && r_s2_c && s2_last) begin
                for (int i = 0; i < NCH; i++) begin
                    for (int j = 0; j < NCH; j++) begin
                        r_cur[i][j] <= (j == int'(r_s2_col)) ? res[i].val : r_cbuf[i][j];
                    end
                end
            end
        end
    end

    // Pipeline payload and composed columns
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_c   <= issue_c;
            r_s1_col <= col;
            for (int i = 0; i < NCH; i++) begin
                for (int k = 0; k < NCH; k++) begin
                    r_s1_p[i][k] <= n_prod[i][k];
                end
            end
            r_s2_c   <= r_s1_c;
            r_s2_col <= r_s1_col;
            for (int i = 0; i < NCH; i++) begin
                r_s2_a[i] <= t_pair'(r_s1_p[i][0]) + t_pair'(r_s1_p[i][1]);
                r_s2_b[i] <= t_pair'(r_s1_p[i][2]) + t_pair'(r_s1_p[i][3]);
            end
            for (int i = 0; i < NCH; i++) begin
                r_out[i] <= res[i].val;
            end
            r_sat <= any_sat;
            if (r_s2_v && r_s2_c) begin
                for (int i = 0; i < NCH; i++) begin
                    r_cbuf[i][r_s2_col] <= res[i].val;
                end
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out       = r_out;
    assign o_saturated = r_sat;

`ifndef SYNTHESIS
    a_busy_blocks_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_q_pop)
        else $error("request taken while compose in progress");
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_issue) <= DIM)
        else $error("compose column count out of range");
    a_compose_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2_c) |-> r_busy)
        else $error("compose column outside a compose");
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_v && !r_s2_c))
        else $error("result without a transform behind it");
    a_no_issue_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(issue_x && issue_c))
        else $error("transform and compose issued together");
`endif

endmodule

FILE: src/homogeneous_transform_engine_unit.sv
// Top level of the 4x4 homogeneous transform engine, signed Q16.16.
// Depends on hte_pkg, hte_front, hte_queue and hte_back.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------------
//  in      | i_in_valid / o_in_ready    | i_command, i_row_index, i_val_0..i_val_3
//  out     | o_out_valid / i_out_ready  | o_out_0..o_out_3, o_saturated
//
// One request per cycle while the queue has room: a vector transform passes
// through the queue, multiply and two-level add stages to the result register.
// Composing (staging the last row) holds the back end for four column passes
// through the shared 16-multiplier array and until they drain.
// Reset loads identity, clears staged rows and empties the queue.
// A result waiting on i_out_ready freezes the back end; the queue keeps taking
// requests until its four entries are full.
module homogeneous_transform_engine_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_command,
    input  logic [1:0]     i_row_index,
    input  hte_pkg::t_word i_val_0,
    input  hte_pkg::t_word i_val_1,
    input  hte_pkg::t_word i_val_2,
    input  hte_pkg::t_word i_val_3,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hte_pkg::t_word o_out_0,
    output hte_pkg::t_word o_out_1,
    output hte_pkg::t_word o_out_2,
    output hte_pkg::t_word o_out_3,
    output logic           o_saturated
);
    import hte_pkg::*;

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_valid;
    t_req            q_in;
    t_req            q_out;
    t_word [NCH-1:0] out_w;

    // Accept and classify
    hte_front u_front (
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_command   (i_command),
        .i_row_index (i_row_index),
        .i_val_0     (i_val_0),
        .i_val_1     (i_val_1),
        .i_val_2     (i_val_2),
        .i_val_3     (i_val_3),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_req     (q_in)
    );

    // Decouple front from back
    hte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (q_in),
        .i_pop   (q_pop),
        .o_req   (q_out),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // Execute
    hte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_req     (q_out),
        .o_q_pop     (q_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_out       (out_w),
        .o_saturated (o_saturated)
    );

    assign o_out_0 = out_w[0];
    assign o_out_1 = out_w[1];
    assign o_out_2 = out_w[2];
    assign o_out_3 = out_w[3];

endmodule
